>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true at a clock edge implies consequent at the same edge.
`define QRS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent true at a clock edge implies consequent at the next edge.
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/qrs_pkg.sv
// Package of types and constants for the quadratic root solver.
package qrs_pkg;

   localparam int COEF_W     = 24;
   localparam int PROD_W     = 2 * COEF_W;
   localparam int DISC_W     = 52;
   localparam int RAD_W      = 50;
   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int SQRT_W     = SQRT_STEPS;
   localparam int SREM_W     = SQRT_W + 1;
   localparam int NUM_W      = 27;
   localparam int DEN_W      = COEF_W + 1;
   localparam int FRAC_BITS  = 16;
   localparam int DVD_W      = NUM_W - 1 + FRAC_BITS;
   localparam int DIV_STEPS  = DVD_W;
   localparam int QUO_W      = DVD_W;
   localparam int DREM_W     = DEN_W;
   localparam int ROOT_W     = 48;
   localparam int LANES      = 2;

   typedef enum logic [1:0] {
      CNT_NONE = 2'd0,
      CNT_ONE  = 2'd1,
      CNT_TWO  = 2'd2,
      CNT_ALL  = 2'd3
   } count_type;

   // Travels with an item through the square root pipeline.
   typedef struct packed {
      count_type                  count;
      logic                       quad;
      logic signed [COEF_W-1:0]   a;
      logic signed [COEF_W-1:0]   b;
      logic signed [COEF_W-1:0]   c;
      logic signed [DISC_W-1:0]   disc;
   } ctl_type;

   // Travels with an item through the divider pipeline.
   typedef struct packed {
      count_type                  count;
      logic signed [DISC_W-1:0]   disc;
   } side_type;

endpackage

>>> hw/rtl/qrs_front.sv
// Front stages: coefficient products, discriminant and case classification.
module qrs_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [qrs_pkg::COEF_W-1:0]  in_a,
   input  logic signed [qrs_pkg::COEF_W-1:0]  in_b,
   input  logic signed [qrs_pkg::COEF_W-1:0]  in_c,
   output logic                               out_valid,
   output logic        [qrs_pkg::RAD_W-1:0]   out_rad,
   output qrs_pkg::ctl_type                   out_ctl
);
   import qrs_pkg::*;

   logic                      valid1_ff;
   logic signed [COEF_W-1:0]  a1_ff, b1_ff, c1_ff;
   logic signed [PROD_W-1:0]  bb_ff, ac_ff, bb_in, ac_in;
   logic                      valid2_ff;
   logic        [RAD_W-1:0]   rad_ff, rad_in;
   ctl_type                   ctl_ff, ctl_in;
   logic signed [DISC_W-1:0]  disc_full;

   assign bb_in = in_b * in_b;
   assign ac_in = in_a * in_c;

   always_comb begin
      disc_full = DISC_W'(bb_ff) - (DISC_W'(ac_ff) <<< 2);
      ctl_in.a    = a1_ff;
      ctl_in.b    = b1_ff;
      ctl_in.c    = c1_ff;
      ctl_in.quad = (a1_ff != '0);
      ctl_in.disc = '0;
      rad_in      = '0;
      if (a1_ff == '0) begin
         if (b1_ff != '0) begin
            ctl_in.count = CNT_ONE;
         end else if (c1_ff == '0) begin
            ctl_in.count = CNT_ALL;
         end else begin
            ctl_in.count = CNT_NONE;
         end
      end else begin
         ctl_in.disc = disc_full;
         if (disc_full[DISC_W-1]) begin
            ctl_in.count = CNT_NONE;
         end else if (disc_full == '0) begin
            ctl_in.count = CNT_ONE;
         end else begin
            ctl_in.count = CNT_TWO;
            rad_in       = disc_full[RAD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff  <= in_a;
      b1_ff  <= in_b;
      c1_ff  <= in_c;
      bb_ff  <= bb_in;
      ac_ff  <= ac_in;
      rad_ff <= rad_in;
      ctl_ff <= ctl_in;
   end

   assign out_valid = valid2_ff;
   assign out_rad   = rad_ff;
   assign out_ctl   = ctl_ff;

endmodule

>>> hw/rtl/qrs_sqrt.sv
// Pipelined floored square root, one root bit per stage.
module qrs_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [qrs_pkg::RAD_W-1:0]        in_rad,
   input  qrs_pkg::ctl_type                 in_ctl,
   output logic                             out_valid,
   output logic [qrs_pkg::SQRT_W-1:0]       out_root,
   output qrs_pkg::ctl_type                 out_ctl
);
   import qrs_pkg::*;

   logic              valid_ff [SQRT_STEPS];
   logic [RAD_W-1:0]  rad_ff   [SQRT_STEPS];
   logic [SREM_W-1:0] rem_ff   [SQRT_STEPS];
   logic [SQRT_W-1:0] root_ff  [SQRT_STEPS];
   ctl_type           ctl_ff   [SQRT_STEPS];

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
      logic              v_src;
      logic [RAD_W-1:0]  rad_src;
      logic [SREM_W-1:0] rem_src, rem_in;
      logic [SQRT_W-1:0] root_src, root_in;
      ctl_type           ctl_src;
      logic [SREM_W+1:0] partial, trial;
      logic              take;

      if (g == 0) begin : g_head
         assign v_src    = in_valid;
         assign rad_src  = in_rad;
         assign rem_src  = '0;
         assign root_src = '0;
         assign ctl_src  = in_ctl;
      end else begin : g_body
         assign v_src    = valid_ff[g-1];
         assign rad_src  = rad_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign ctl_src  = ctl_ff[g-1];
      end

      // Bring down two radicand bits, try the next root bit.
      always_comb begin
         partial = {rem_src, rad_src[RAD_W-1 -: 2]};
         trial   = {1'b0, root_src, 2'b01};
         take    = (partial >= trial);
         rem_in  = take ? SREM_W'(partial - trial) : partial[SREM_W-1:0];
         root_in = {root_src[SQRT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[g]  <= {rad_src[RAD_W-3:0], 2'b00};
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         ctl_ff[g]  <= ctl_src;
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];
   assign out_ctl   = ctl_ff[SQRT_STEPS-1];

endmodule

>>> hw/rtl/qrs_div.sv
// Two-lane pipelined signed divider, one quotient bit per stage.
module qrs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [qrs_pkg::NUM_W-1:0]  in_num [qrs_pkg::LANES],
   input  logic signed [qrs_pkg::DEN_W-1:0]  in_den,
   input  qrs_pkg::side_type                 in_side,
   output logic                              out_valid,
   output logic        [qrs_pkg::QUO_W-1:0]  out_quo [qrs_pkg::LANES],
   output logic                              out_neg [qrs_pkg::LANES],
   output qrs_pkg::side_type                 out_side
);
   import qrs_pkg::*;

   logic              valid_ff [DIV_STEPS];
   side_type          side_ff  [DIV_STEPS];
   logic [DEN_W-1:0]  dsr_ff   [DIV_STEPS];
   logic [DVD_W-1:0]  dvd_ff   [DIV_STEPS][LANES];
   logic [DREM_W-1:0] rem_ff   [DIV_STEPS][LANES];
   logic [QUO_W-1:0]  quo_ff   [DIV_STEPS][LANES];
   logic              neg_ff   [DIV_STEPS][LANES];

   logic [DEN_W-1:0]  den_mag;
   assign den_mag = in_den[DEN_W-1] ? DEN_W'(-in_den) : DEN_W'(in_den);

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
      logic             v_src;
      side_type         side_src;
      logic [DEN_W-1:0] dsr_src;

      if (g == 0) begin : g_head
         assign v_src    = in_valid;
         assign side_src = in_side;
         assign dsr_src  = den_mag;
      end else begin : g_body
         assign v_src    = valid_ff[g-1];
         assign side_src = side_ff[g-1];
         assign dsr_src  = dsr_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         side_ff[g] <= side_src;
         dsr_ff[g]  <= dsr_src;
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DVD_W-1:0]  dvd_src;
         logic [DREM_W-1:0] rem_src, rem_in;
         logic [QUO_W-1:0]  quo_src;
         logic              neg_src;
         logic [DREM_W:0]   partial;
         logic              take;

         if (g == 0) begin : g_head
            logic [NUM_W-2:0] num_mag;
            assign num_mag = in_num[l][NUM_W-1] ? (NUM_W-1)'(-in_num[l])
                                                : in_num[l][NUM_W-2:0];
            assign dvd_src = {num_mag, {FRAC_BITS{1'b0}}};
            assign rem_src = '0;
            assign quo_src = '0;
            assign neg_src = in_num[l][NUM_W-1] ^ in_den[DEN_W-1];
         end else begin : g_body
            assign dvd_src = dvd_ff[g-1][l];
            assign rem_src = rem_ff[g-1][l];
            assign quo_src = quo_ff[g-1][l];
            assign neg_src = neg_ff[g-1][l];
         end

         // Shift in the next dividend bit, subtract the divisor if it fits.
         always_comb begin
            partial = {rem_src, dvd_src[DVD_W-1]};
            take    = (partial >= {1'b0, dsr_src});
            rem_in  = take ? DREM_W'(partial - {1'b0, dsr_src}) : partial[DREM_W-1:0];
         end

         always_ff @(posedge clock) begin
            dvd_ff[g][l] <= {dvd_src[DVD_W-2:0], 1'b0};
            rem_ff[g][l] <= rem_in;
            quo_ff[g][l] <= {quo_src[QUO_W-2:0], take};
            neg_ff[g][l] <= neg_src;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];
   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quo[l] = quo_ff[DIV_STEPS-1][l];
      assign out_neg[l] = neg_ff[DIV_STEPS-1][l];
   end

endmodule

>>> hw/rtl/quadratic_root_solver.sv
// Top level of the quadratic root solver: front, square root, divider, output.
//
// Usage: drive req_coef_a/b/c (signed Q12.12) and raise start; the request is
// taken at every rising edge with start high and busy low. busy stays low:
// the pipeline advances every cycle, so one request may enter each cycle.
// Each request yields exactly one response, shown for one cycle with
// rsp_strobe high: root count, both roots (signed Q32.16, zero when absent),
// the discriminant b*b-4ac (signed Q28.24, zero for the linear case) and the
// saturation flag. A request passes from the accepting edge through 2 front
// stages (products, discriminant), 25 square root stages (one root bit each),
// 1 operand stage, 42 divider stages (one quotient bit each) and the output
// register. Throughput is one request per cycle. The receiver cannot stall;
// responses are never held. Reset clears every valid bit in the pipeline,
// dropping requests in flight; no request is lost or repeated otherwise.
module quadratic_root_solver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_a,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_b,
   input  logic signed [qrs_pkg::COEF_W-1:0]   req_coef_c,
   output logic                                rsp_strobe,
   output logic        [1:0]                   rsp_root_count,
   output logic signed [qrs_pkg::ROOT_W-1:0]   rsp_first_root,
   output logic signed [qrs_pkg::ROOT_W-1:0]   rsp_second_root,
   output logic signed [qrs_pkg::DISC_W-1:0]   rsp_discriminant,
   output logic                                rsp_saturated
);
   import qrs_pkg::*;
   `include "assert_macros.svh"

   // Front: products and discriminant.
   logic             fr_valid;
   logic [RAD_W-1:0] fr_rad;
   ctl_type          fr_ctl;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_a      (req_coef_a),
      .in_b      (req_coef_b),
      .in_c      (req_coef_c),
      .out_valid (fr_valid),
      .out_rad   (fr_rad),
      .out_ctl   (fr_ctl)
   );

   // Square root of the discriminant (zero when it is not used).
   logic              sq_valid;
   logic [SQRT_W-1:0] sq_root;
   ctl_type           sq_ctl;

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_ctl    (fr_ctl),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_ctl   (sq_ctl)
   );

   // Operand stage: pick numerators and divisor for each case. Unused roots
   // get a zero numerator, and the divisor is forced to one where b is zero
   // in the linear case, so that every lane divides safely.
   logic                     op_valid_ff;
   logic signed [NUM_W-1:0]  num_ff [LANES];
   logic signed [NUM_W-1:0]  num_in [LANES];
   logic signed [DEN_W-1:0]  den_ff, den_in;
   side_type                 side_ff, side_in;
   logic signed [NUM_W-1:0]  neg_b, root_ext;

   always_comb begin
      neg_b        = -NUM_W'(sq_ctl.b);
      root_ext     = $signed(NUM_W'(sq_root));
      num_in[0]    = '0;
      num_in[1]    = '0;
      den_in       = DEN_W'(sq_ctl.a) <<< 1;
      side_in.count = sq_ctl.count;
      side_in.disc  = sq_ctl.disc;
      if (sq_ctl.quad) begin
         case (sq_ctl.count)
            CNT_TWO: begin
               num_in[0] = neg_b + root_ext;
               num_in[1] = neg_b - root_ext;
            end
            CNT_ONE: begin
               num_in[0] = neg_b;
            end
            default: begin
            end
         endcase
      end else if (sq_ctl.count == CNT_ONE) begin
         // Linear root -c/b: truncation is symmetric, so negate the numerator.
         num_in[0] = -NUM_W'(sq_ctl.c);
         den_in    = DEN_W'(sq_ctl.b);
      end else begin
         den_in    = DEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= num_in[0];
      num_ff[1] <= num_in[1];
      den_ff    <= den_in;
      side_ff   <= side_in;
   end

   // Divider lanes: lane 0 gives the first root, lane 1 the second.
   logic             dv_valid;
   logic [QUO_W-1:0] dv_quo [LANES];
   logic             dv_neg [LANES];
   side_type         dv_side;

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (op_valid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_neg   (dv_neg),
      .out_side  (dv_side)
   );

   // Output register: restore the sign of each quotient.
   logic                     strobe_ff;
   count_type                count_ff;
   logic signed [ROOT_W-1:0] root_ff [LANES];
   logic signed [ROOT_W-1:0] root_in [LANES];
   logic signed [DISC_W-1:0] disc_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         root_in[l] = dv_neg[l] ? -$signed(ROOT_W'(dv_quo[l]))
                                : $signed(ROOT_W'(dv_quo[l]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= dv_side.count;
      disc_ff    <= dv_side.disc;
      root_ff[0] <= root_in[0];
      root_ff[1] <= root_in[1];
   end

   assign busy             = 1'b0;
   assign rsp_strobe       = strobe_ff;
   assign rsp_root_count   = count_ff;
   assign rsp_first_root   = root_ff[0];
   assign rsp_second_root  = root_ff[1];
   assign rsp_discriminant = disc_ff;
   // Quotients span at most 43 signed bits, so the Q32.16 clamp never fires.
   assign rsp_saturated    = 1'b0;

   `QRS_ASSERT_IMPLY(a_second_zero, strobe_ff && count_ff != CNT_TWO, root_ff[1] == '0, "second root must be zero unless two roots")
   `QRS_ASSERT_IMPLY(a_none_zero, strobe_ff && (count_ff == CNT_NONE || count_ff == CNT_ALL), root_ff[0] == '0, "first root must be zero when no single root")
   `QRS_ASSERT_IMPLY(a_all_disc, strobe_ff && count_ff == CNT_ALL, disc_ff == '0, "identity case must report zero discriminant")
   `QRS_ASSERT_NEXT(a_strobe_flow, dv_valid, strobe_ff, "divider result must reach the output next cycle")

endmodule
